// ===== hw/rtl/kl_pkg.sv =====
// Shared types and constants of the keyword lexer.
`timescale 1ns / 1ps
`default_nettype none

package kl_pkg;

    typedef enum logic [3:0] {
        TK_SEMI    = 4'd0,
        TK_EQUALS  = 4'd1,
        TK_LPAREN  = 4'd2,
        TK_RPAREN  = 4'd3,
        TK_PLUS    = 4'd4,
        TK_IDENT   = 4'd5,
        TK_INTEGER = 4'd6,
        TK_PRINT   = 4'd7,
        TK_LET     = 4'd8,
        TK_WHILE   = 4'd9,
        TK_EOF     = 4'd10
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [63:0] text;
        logic [15:0] length;
        logic        truncated;
        logic [15:0] line;
        logic        last;
    } res_t;

    localparam int MAX_PUSH    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PUSH_W      = $clog2(MAX_PUSH + 1);

    typedef struct packed {
        logic [PUSH_W-1:0]       num;
        res_t [MAX_PUSH-1:0]     item;
    } push_t;

    localparam logic [15:0] LINE_MAX = 16'hFFFF;
    localparam logic [15:0] LEN_MAX  = 16'hFFFF;

    localparam logic [63:0] TEXT_LET   = 64'h0000_0000_0074_656C;
    localparam logic [63:0] TEXT_WHILE = 64'h0000_0065_6C69_6877;
    localparam logic [63:0] TEXT_PRINT = 64'h0000_0074_6E69_7270;
    localparam logic [63:0] TEXT_EOF   = 64'h0000_0000_0046_4F45;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_UNDER = 8'h5F;

endpackage

`default_nettype wire

// ===== hw/rtl/kl_scan.sv =====
// Input register, word and line state, and per-character token generation.
`timescale 1ns / 1ps
`default_nettype none

module kl_scan #(
    parameter int TEXT_BYTES = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         src_valid,
    output logic              src_stall,
    input  wire logic [7:0]   char_code,
    input  wire logic         has_char,
    input  wire logic         end_of_source,
    input  wire logic         room,
    output kl_pkg::push_t     push
);

    localparam int TW = TEXT_BYTES * 8;

    logic          in_vld_reg;
    logic [7:0]    chr_reg;
    logic          has_reg;
    logic          eos_reg;

    logic [TW-1:0] text_reg, text_next;
    logic [15:0]   len_reg, len_next;
    logic          digits_reg, digits_next;
    logic          ident_reg, ident_next;
    logic [15:0]   line_reg, line_next;

    logic          take;
    logic          is_space, is_single, is_digit, is_lower, is_upper;
    logic          gathers, flush_req, word_found;
    kl_pkg::token_kind_t single_kind, word_kind;

    logic [TW-1:0] g_text;
    logic [15:0]   g_len;
    logic          g_digits, g_ident;
    logic [63:0]   g_text64;

    kl_pkg::res_t [kl_pkg::MAX_PUSH-1:0] cand;
    kl_pkg::res_t [kl_pkg::MAX_PUSH-1:0] comp;
    logic [kl_pkg::MAX_PUSH-1:0]         cv;
    logic [kl_pkg::PUSH_W-1:0]           n;

    assign take      = in_vld_reg && room;
    assign src_stall = in_vld_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!src_stall)
        begin
            in_vld_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!src_stall && src_valid)
        begin
            chr_reg <= char_code;
            has_reg <= has_char;
            eos_reg <= end_of_source;
        end
    end

    always_comb
    begin
        is_space = (chr_reg == kl_pkg::CH_SPACE) || (chr_reg == kl_pkg::CH_TAB)
                || (chr_reg == kl_pkg::CH_LF) || (chr_reg == kl_pkg::CH_VT)
                || (chr_reg == kl_pkg::CH_FF) || (chr_reg == kl_pkg::CH_CR);
        is_digit = (chr_reg >= 8'h30) && (chr_reg <= 8'h39);
        is_lower = (chr_reg >= 8'h61) && (chr_reg <= 8'h7A);
        is_upper = (chr_reg >= 8'h41) && (chr_reg <= 8'h5A);
    end

    always_comb
    begin
        is_single   = 1'b1;
        single_kind = kl_pkg::TK_SEMI;
        unique case (chr_reg)
            kl_pkg::CH_SEMI: single_kind = kl_pkg::TK_SEMI;
            kl_pkg::CH_EQ:   single_kind = kl_pkg::TK_EQUALS;
            kl_pkg::CH_LPAR: single_kind = kl_pkg::TK_LPAREN;
            kl_pkg::CH_RPAR: single_kind = kl_pkg::TK_RPAREN;
            kl_pkg::CH_PLUS: single_kind = kl_pkg::TK_PLUS;
            default:         is_single   = 1'b0;
        endcase
    end

    // gather the byte into the word when it is neither a delimiter nor absent
    always_comb
    begin
        gathers  = has_reg && !is_space && !is_single;
        g_text   = text_reg;
        g_len    = len_reg;
        g_digits = digits_reg;
        g_ident  = ident_reg;
        if (gathers)
        begin
            if (!is_digit)
            begin
                g_digits = 1'b0;
            end
            if (len_reg == 16'd0)
            begin
                if (!is_lower)
                begin
                    g_ident = 1'b0;
                end
            end
            else if (!(is_digit || is_lower || is_upper || chr_reg == kl_pkg::CH_UNDER))
            begin
                g_ident = 1'b0;
            end
            for (int b = 0; b < TEXT_BYTES; b++)
            begin
                if (len_reg == 16'(b))
                begin
                    g_text[b*8 +: 8] = chr_reg;
                end
            end
            if (len_reg != kl_pkg::LEN_MAX)
            begin
                g_len = len_reg + 16'd1;
            end
        end
        g_text64 = 64'(g_text);
    end

    always_comb
    begin
        word_found = 1'b1;
        word_kind  = kl_pkg::TK_IDENT;
        if (g_len == 16'd3 && g_text64 == kl_pkg::TEXT_LET)
        begin
            word_kind = kl_pkg::TK_LET;
        end
        else if (g_len == 16'd5 && g_text64 == kl_pkg::TEXT_WHILE)
        begin
            word_kind = kl_pkg::TK_WHILE;
        end
        else if (g_len == 16'd5 && g_text64 == kl_pkg::TEXT_PRINT)
        begin
            word_kind = kl_pkg::TK_PRINT;
        end
        else if (g_digits)
        begin
            word_kind = kl_pkg::TK_INTEGER;
        end
        else if (!g_ident)
        begin
            word_found = 1'b0;
        end
    end

    assign flush_req = (has_reg && (is_space || is_single)) || eos_reg;

    always_comb
    begin
        cv[0] = flush_req && (g_len != 16'd0) && word_found;
        cv[1] = has_reg && is_single;
        cv[2] = eos_reg;

        line_next = line_reg;
        if (has_reg && chr_reg == kl_pkg::CH_LF && line_reg != kl_pkg::LINE_MAX)
        begin
            line_next = line_reg + 16'd1;
        end

        cand[0].kind      = word_kind;
        cand[0].text      = g_text64;
        cand[0].length    = g_len;
        cand[0].truncated = g_len > 16'(TEXT_BYTES);
        cand[0].line      = line_reg;
        cand[0].last      = !cv[1] && !cv[2];

        cand[1].kind      = single_kind;
        cand[1].text      = 64'(chr_reg);
        cand[1].length    = 16'd1;
        cand[1].truncated = 1'b0;
        cand[1].line      = line_reg;
        cand[1].last      = !cv[2];

        cand[2].kind      = kl_pkg::TK_EOF;
        cand[2].text      = kl_pkg::TEXT_EOF;
        cand[2].length    = 16'd3;
        cand[2].truncated = 1'b0;
        cand[2].line      = line_next;
        cand[2].last      = 1'b1;
    end

    // pack the valid results to the front, in order
    always_comb
    begin
        comp = '0;
        n    = '0;
        for (int i = 0; i < kl_pkg::MAX_PUSH; i++)
        begin
            if (cv[i])
            begin
                comp[n[1:0]] = cand[i];
                n = n + kl_pkg::PUSH_W'(1);
            end
        end
        push.item = comp;
        push.num  = take ? n : '0;
    end

    always_comb
    begin
        text_next   = g_text;
        len_next    = g_len;
        digits_next = g_digits;
        ident_next  = g_ident;
        if (flush_req)
        begin
            text_next   = '0;
            len_next    = '0;
            digits_next = 1'b1;
            ident_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_reg   <= '0;
            len_reg    <= '0;
            digits_reg <= 1'b1;
            ident_reg  <= 1'b1;
            line_reg   <= 16'd1;
        end
        else if (take)
        begin
            text_reg   <= text_next;
            len_reg    <= len_next;
            digits_reg <= digits_next;
            ident_reg  <= ident_next;
            line_reg   <= eos_reg ? 16'd1 : line_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kl_res_queue.sv =====
// Result queue: takes up to three tokens a cycle, hands out one token a cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module kl_res_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire kl_pkg::push_t push,
    output logic               room,
    output logic               tok_valid,
    input  wire logic          tok_stall,
    output kl_pkg::res_t       head
);

    kl_pkg::res_t [kl_pkg::QUEUE_DEPTH-1:0] mem_reg;
    logic [kl_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [kl_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [kl_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic [kl_pkg::QCNT_W-1:0]  cnt_after_pop;
    logic                       pop;

    assign tok_valid     = cnt_reg != '0;
    assign pop           = tok_valid && !tok_stall;
    assign head          = mem_reg[rd_ptr_reg];
    assign cnt_after_pop = cnt_reg - kl_pkg::QCNT_W'(pop);
    assign room          = cnt_after_pop
                           <= kl_pkg::QCNT_W'(kl_pkg::QUEUE_DEPTH - kl_pkg::MAX_PUSH);
    assign cnt_next      = cnt_after_pop + kl_pkg::QCNT_W'(push.num);

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < kl_pkg::MAX_PUSH; j++)
        begin
            if (kl_pkg::PUSH_W'(j) < push.num)
            begin
                mem_reg[wr_ptr_reg + kl_pkg::QPTR_W'(j)] <= push.item[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_reg + kl_pkg::QPTR_W'(pop);
            wr_ptr_reg <= wr_ptr_reg + kl_pkg::QPTR_W'(push.num);
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/keyword_lexer_top.sv =====
// Keyword lexer top level: character channel in, token channel out.
//
// Source channel: one character word per handshake (src_valid high, src_stall
// low). has_char low with end_of_source low is ignored. end_of_source flushes
// the pending word, emits an EOF token and restarts on line 1.
// Token channel: one token per handshake (tok_valid high, tok_stall low);
// last_result marks the final token caused by one character word.
// A character's tokens pass through the input register, then the result queue,
// before they reach the token channel.
// Throughput: one character per cycle while each gives at most one token and
// tok_stall is low. A character that gives two or three tokens hands them out
// over as many handshakes; the four-entry result queue accepts a character
// only with three free entries after the current pop, so tok_stall backs up
// into src_stall in the same cycle.
// Reset: clears the word, sets the line to 1 and empties the queue.
// A stalled token holds steady until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module keyword_lexer_top #(
    parameter int TEXT_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        src_valid,
    output logic             src_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        has_char,
    input  wire logic        end_of_source,
    output logic             tok_valid,
    input  wire logic        tok_stall,
    output logic [3:0]       token_kind,
    output logic [63:0]      token_text,
    output logic [15:0]      token_length,
    output logic             text_truncated,
    output logic [15:0]      token_line,
    output logic             last_result
);

    kl_pkg::push_t push;
    kl_pkg::res_t  head;
    logic          room;

    kl_scan #(
        .TEXT_BYTES (TEXT_BYTES)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .char_code     (char_code),
        .has_char      (has_char),
        .end_of_source (end_of_source),
        .room          (room),
        .push          (push)
    );

    kl_res_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .head      (head)
    );

    assign token_kind     = head.kind;
    assign token_text     = head.text;
    assign token_length   = head.length;
    assign text_truncated = head.truncated;
    assign token_line     = head.line;
    assign last_result    = head.last;

endmodule

`default_nettype wire

// ===== test/keyword_lexer_top_tb.sv =====
// Self-checking testbench for the keyword lexer: character streams in, predicted tokens checked.
`timescale 1ns / 1ps

class token_ledger;
    kl_pkg::res_t expected_tokens[$];
    logic [63:0]  word_text;
    logic [15:0]  word_len;
    bit           all_digits;
    bit           ident_ok;
    logic [15:0]  line_no;
    int           errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void clear_word();
        word_text  = '0;
        word_len   = '0;
        all_digits = 1'b1;
        ident_ok   = 1'b1;
    endfunction

    function void restart();
        clear_word();
        line_no = 16'd1;
    endfunction

    function void push_token(kl_pkg::token_kind_t kind, logic [63:0] text, logic [15:0] len);
        kl_pkg::res_t r;
        r.kind      = kind;
        r.text      = text;
        r.length    = len;
        r.truncated = (len > 8);
        r.line      = line_no;
        r.last      = 1'b0;
        expected_tokens = {expected_tokens, r};
    endfunction

    function void flush_word();
        if (word_len != 0)
        begin
            if (word_len == 16'd3 && word_text == kl_pkg::TEXT_LET)
                push_token(kl_pkg::TK_LET, word_text, word_len);
            else if (word_len == 16'd5 && word_text == kl_pkg::TEXT_WHILE)
                push_token(kl_pkg::TK_WHILE, word_text, word_len);
            else if (word_len == 16'd5 && word_text == kl_pkg::TEXT_PRINT)
                push_token(kl_pkg::TK_PRINT, word_text, word_len);
            else if (all_digits)
                push_token(kl_pkg::TK_INTEGER, word_text, word_len);
            else if (ident_ok)
                push_token(kl_pkg::TK_IDENT, word_text, word_len);
        end
        clear_word();
    endfunction

    function void note_char(logic [7:0] c, logic hc, logic eos);
        int                  first;
        kl_pkg::token_kind_t kind;
        bit                  digit;
        bit                  lower;
        bit                  upper;
        first = expected_tokens.size();
        if (hc)
        begin
            case (c)
                kl_pkg::CH_SPACE, kl_pkg::CH_TAB, kl_pkg::CH_LF, kl_pkg::CH_VT,
                kl_pkg::CH_FF, kl_pkg::CH_CR:
                begin
                    flush_word();
                    if (c == kl_pkg::CH_LF && line_no != kl_pkg::LINE_MAX)
                        line_no++;
                end
                kl_pkg::CH_SEMI, kl_pkg::CH_EQ, kl_pkg::CH_LPAR, kl_pkg::CH_RPAR,
                kl_pkg::CH_PLUS:
                begin
                    flush_word();
                    case (c)
                        kl_pkg::CH_SEMI: kind = kl_pkg::TK_SEMI;
                        kl_pkg::CH_EQ:   kind = kl_pkg::TK_EQUALS;
                        kl_pkg::CH_LPAR: kind = kl_pkg::TK_LPAREN;
                        kl_pkg::CH_RPAR: kind = kl_pkg::TK_RPAREN;
                        default:         kind = kl_pkg::TK_PLUS;
                    endcase
                    push_token(kind, {56'd0, c}, 16'd1);
                end
                default:
                begin
                    digit = (c >= "0" && c <= "9");
                    lower = (c >= "a" && c <= "z");
                    upper = (c >= "A" && c <= "Z");
                    if (!digit)
                        all_digits = 1'b0;
                    if (word_len == 0)
                    begin
                        if (!lower)
                            ident_ok = 1'b0;
                    end
                    else if (!(digit || lower || upper || c == kl_pkg::CH_UNDER))
                        ident_ok = 1'b0;
                    if (word_len < 8)
                        word_text = word_text | (64'(c) << (8 * word_len));
                    if (word_len != kl_pkg::LEN_MAX)
                        word_len++;
                end
            endcase
        end
        if (eos)
        begin
            flush_word();
            push_token(kl_pkg::TK_EOF, kl_pkg::TEXT_EOF, 16'd3);
            restart();
        end
        if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    function void check_token(logic [3:0] kind, logic [63:0] text, logic [15:0] len,
                              logic trunc, logic [15:0] line, logic last);
        kl_pkg::res_t want;
        if (expected_tokens.size() == 0)
        begin
            $error("token_kind %0d arrived with no token expected", kind);
            errors++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            if (kind !== want.kind)
            begin
                $error("token_kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (text !== want.text)
            begin
                $error("token_text: expected %h, got %h", want.text, text);
                errors++;
            end
            if (len !== want.length)
            begin
                $error("token_length: expected %0d, got %0d", want.length, len);
                errors++;
            end
            if (trunc !== want.truncated)
            begin
                $error("text_truncated: expected %0d, got %0d", want.truncated, trunc);
                errors++;
            end
            if (line !== want.line)
            begin
                $error("token_line: expected %0d, got %0d", want.line, line);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_result: expected %0d, got %0d", want.last, last);
                errors++;
            end
        end
    endfunction
endclass

module keyword_lexer_top_tb;

    localparam int HALF_PERIOD = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 5000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        src_valid     = 1'b0;
    logic        src_stall;
    logic [7:0]  char_code     = '0;
    logic        has_char      = 1'b0;
    logic        end_of_source = 1'b0;
    logic        tok_valid;
    logic        tok_stall     = 1'b0;
    logic [3:0]  token_kind;
    logic [63:0] token_text;
    logic [15:0] token_length;
    logic        text_truncated;
    logic [15:0] token_line;
    logic        last_result;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asked    = 0;
    int hold_given    = 0;
    int hold_left     = 0;
    int words_sent    = 0;
    int quiet_cycles  = 0;

    token_ledger ledger = new();

    keyword_lexer_top #(.TEXT_BYTES(8)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_valid      (src_valid),
        .src_stall      (src_stall),
        .char_code      (char_code),
        .has_char       (has_char),
        .end_of_source  (end_of_source),
        .tok_valid      (tok_valid),
        .tok_stall      (tok_stall),
        .token_kind     (token_kind),
        .token_text     (token_text),
        .token_length   (token_length),
        .text_truncated (text_truncated),
        .token_line     (token_line),
        .last_result    (last_result)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tok_valid && !tok_stall)
                ledger.check_token(token_kind, token_text, token_length, text_truncated,
                                   token_line, last_result);
            if (src_valid && !src_stall)
                ledger.note_char(char_code, has_char, end_of_source);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tok_valid && !tok_stall) || (src_valid && !src_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // hold off the token side for a long stretch on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            tok_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_given != hold_asked)
        begin
            tok_stall  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            hold_given <= hold_asked;
        end
        else
            tok_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(input logic [7:0] c, input logic hc, input logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid     <= 1'b1;
        char_code     <= c;
        has_char      <= hc;
        end_of_source <= eos;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        if (hc || eos)
            words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b1, 1'b0);
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        @(posedge clk);
        while (ledger.expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] space_char();
        case ($urandom_range(6))
            0:       return kl_pkg::CH_TAB;
            1, 2:    return kl_pkg::CH_LF;
            3:       return kl_pkg::CH_VT;
            4:       return kl_pkg::CH_FF;
            5:       return kl_pkg::CH_CR;
            default: return kl_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] delim_char();
        case ($urandom_range(4))
            0:       return kl_pkg::CH_SEMI;
            1:       return kl_pkg::CH_EQ;
            2:       return kl_pkg::CH_LPAR;
            3:       return kl_pkg::CH_RPAR;
            default: return kl_pkg::CH_PLUS;
        endcase
    endfunction

    function automatic logic [7:0] ident_char();
        case ($urandom_range(3))
            0:       return "a" + 8'($urandom_range(25));
            1:       return "A" + 8'($urandom_range(25));
            2:       return "0" + 8'($urandom_range(9));
            default: return kl_pkg::CH_UNDER;
        endcase
    endfunction

    task automatic send_fragment();
        string words[6] = '{"let", "while", "print", "lets", "whil", "Print"};
        int    n;
        case ($urandom_range(11))
            0, 1:
                send_text(words[$urandom_range(5)]);
            2, 3, 4:
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(8, 12) : $urandom_range(5);
                send_item("a" + 8'($urandom_range(25)), 1'b1, 1'b0);
                repeat (n)
                    send_item(ident_char(), 1'b1, 1'b0);
            end
            5, 6:
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
                repeat (n)
                    send_item("0" + 8'($urandom_range(9)), 1'b1, 1'b0);
            end
            7:
                send_item(delim_char(), 1'b1, 1'b0);
            8:
                repeat ($urandom_range(1, 4))
                    send_item(8'($urandom_range(255)), 1'b1, 1'b0);
            9:
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            10:
                send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            default:
                repeat ($urandom_range(1, 3))
                    send_item(space_char(), 1'b1, 1'b0);
        endcase
        case ($urandom_range(3))
            0, 1:    send_item(space_char(), 1'b1, 1'b0);
            2:       send_item(delim_char(), 1'b1, 1'b0);
            default: ;
        endcase
    endtask

    initial
    begin
        int target;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        send_text("while(9)=x+y;");
        send_item(kl_pkg::CH_LF, 1'b1, 1'b0);
        send_text("let");
        send_item(kl_pkg::CH_VT, 1'b1, 1'b0);
        send_text("print");
        send_item(kl_pkg::CH_FF, 1'b1, 1'b0);
        send_item(kl_pkg::CH_CR, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(kl_pkg::CH_TAB, 1'b1, 1'b0);
        send_text("abcdefghi");
        send_item(kl_pkg::CH_LF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_text("k_Z9");
        send_item(kl_pkg::CH_RPAR, 1'b1, 1'b1);
        send_text("42");
        send_item(8'h00, 1'b0, 1'b1);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 54;
                    stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct <= 54;
                end
                default:
                begin
                    send_idle_pct = 35;
                    stall_pct <= 35;
                end
            endcase
            if (phase == 0)
            begin
                hold_asked <= hold_asked + 1;
                target = words_sent + 18;
                while (words_sent < target)
                    send_fragment();
            end
            target = words_sent + 20;
            while (words_sent < target)
                send_fragment();
            drain();
        end

        repeat (8)
            @(posedge clk);
        if (ledger.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
